[sv/sfcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the SPI flash command sequencer.
package sfcs_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_PROGRAM   = 3'd1;
  localparam logic [2:0] OP_SECTOR    = 3'd2;
  localparam logic [2:0] OP_SUBSECTOR = 3'd3;
  localparam logic [2:0] OP_DIE       = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  // SPI command bytes.
  localparam logic [7:0] CMD_NONE         = 8'h00;
  localparam logic [7:0] CMD_READ         = 8'h03;
  localparam logic [7:0] CMD_PROGRAM      = 8'h02;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'hD8;
  localparam logic [7:0] CMD_SUBSEC_ERASE = 8'h20;
  localparam logic [7:0] CMD_DIE_ERASE    = 8'hC4;
  localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROGRAM_TIME = 2'd0;
  localparam logic [1:0] REG_SECTOR_ERASE = 2'd1;
  localparam logic [1:0] REG_SUBSEC_ERASE = 2'd2;
  localparam logic [1:0] REG_DIE_ERASE    = 2'd3;

  // Reset values of the duration registers.
  localparam logic [15:0] PROGRAM_TIME_RESET = 16'd5;
  localparam logic [15:0] SECTOR_ERASE_RESET = 16'd3000;
  localparam logic [15:0] SUBSEC_ERASE_RESET = 16'd800;
  localparam logic [19:0] DIE_ERASE_RESET    = 20'd480000;

  // Unit range limits.
  localparam logic [17:0] SECTOR_MAX = 18'd1023;
  localparam logic [17:0] SUBSEC_MAX = 18'd16383;
  localparam logic [17:0] DIE_MAX    = 18'd1;

  // Page program data length.
  localparam logic [26:0] PAGE_BYTES = 27'd256;

  // Stream word widths.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;
  localparam int CFG_DATA_W = 20;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [25:0] byte_address;
    logic [26:0] byte_count;
    logic [17:0] unit_number;
    logic [31:0] now_ms;
  } request_t;

  typedef struct packed {
    logic [15:0] program_time_ms;
    logic [15:0] sector_erase_ms;
    logic [15:0] subsector_erase_ms;
    logic [19:0] die_erase_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [25:0] spi_address;
    logic [26:0] data_length;
    logic        data_is_read;
    logic        rejected;
    logic [31:0] time_left_ms;
    logic        last;
  } result_t;

  // One decoded request: one or two result words.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } pair_t;

endpackage

[sv/sfcs_cfg_regs.sv]
`timescale 1ns / 1ps
// Duration configuration registers of the SPI flash command sequencer.
module sfcs_cfg_regs
  import sfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.program_time_ms    <= PROGRAM_TIME_RESET;
      cfg.sector_erase_ms    <= SECTOR_ERASE_RESET;
      cfg.subsector_erase_ms <= SUBSEC_ERASE_RESET;
      cfg.die_erase_ms       <= DIE_ERASE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROGRAM_TIME: cfg.program_time_ms    <= cfg_data[15:0];
        REG_SECTOR_ERASE: cfg.sector_erase_ms    <= cfg_data[15:0];
        REG_SUBSEC_ERASE: cfg.subsector_erase_ms <= cfg_data[15:0];
        REG_DIE_ERASE:    cfg.die_erase_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/sfcs_decode.sv]
`timescale 1ns / 1ps
// Input register, request decode and completion time tracking.
module sfcs_decode
  import sfcs_pkg::*;
#(
  parameter logic [32:0] DIE_BYTES = 33'd33554432
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  cfg_t                 cfg,
  input  logic                 take,
  output logic                 pair_valid,
  output pair_t                pair
);

  localparam logic [32:0] DIE_PLUS_ONE = DIE_BYTES + 33'd1;

  logic        req_valid;
  request_t    req;
  logic [31:0] completion_time;
  logic [31:0] completion_time_next;

  logic [27:0] read_end;
  logic [32:0] first_len;
  logic        split;
  logic        ok;
  logic        erase;
  logic [7:0]  erase_cmd;
  logic [25:0] erase_addr;
  logic [31:0] duration;
  logic [31:0] time_left;
  result_t     wr_en;
  result_t     main;

  assign s_tready   = !req_valid || take;
  assign pair_valid = req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req.opcode       <= s_tdata[2:0];
      req.byte_address <= s_tdata[28:3];
      req.byte_count   <= s_tdata[55:29];
      req.unit_number  <= s_tdata[73:56];
      req.now_ms       <= s_tdata[105:74];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      completion_time <= '0;
    end else if (take) begin
      completion_time <= completion_time_next;
    end
  end

  // Read range check and die boundary split.
  assign read_end  = {2'b00, req.byte_address} + {1'b0, req.byte_count} - 28'd1;
  assign first_len = DIE_BYTES - {7'd0, req.byte_address};
  assign split     = ({7'd0, req.byte_address} < DIE_BYTES) &&
                     ({5'd0, read_end} >= DIE_BYTES);

  always_comb begin
    ok                   = 1'b1;
    erase                = 1'b0;
    erase_cmd            = CMD_NONE;
    erase_addr           = '0;
    duration             = '0;
    completion_time_next = completion_time;
    case (req.opcode)
      OP_READ: begin
        ok = (req.byte_count != 27'd0) && (read_end[27:26] == 2'b00);
        if (ok) completion_time_next = '0;
      end
      OP_PROGRAM: begin
        erase      = 1'b1;
        erase_cmd  = CMD_PROGRAM;
        erase_addr = {req.unit_number, 8'd0};
        duration   = {16'd0, cfg.program_time_ms};
      end
      OP_SECTOR: begin
        ok         = req.unit_number <= SECTOR_MAX;
        erase      = 1'b1;
        erase_cmd  = CMD_SECTOR_ERASE;
        erase_addr = {req.unit_number[9:0], 16'd0};
        duration   = {16'd0, cfg.sector_erase_ms};
      end
      OP_SUBSECTOR: begin
        ok         = req.unit_number <= SUBSEC_MAX;
        erase      = 1'b1;
        erase_cmd  = CMD_SUBSEC_ERASE;
        erase_addr = {req.unit_number[13:0], 12'd0};
        duration   = {16'd0, cfg.subsector_erase_ms};
      end
      OP_DIE: begin
        ok         = req.unit_number <= DIE_MAX;
        erase      = 1'b1;
        erase_cmd  = CMD_DIE_ERASE;
        erase_addr = req.unit_number[0] ? DIE_PLUS_ONE[25:0] : 26'd0;
        duration   = {12'd0, cfg.die_erase_ms};
      end
      OP_QUERY: ;
      default: ok = 1'b0;
    endcase
    if (ok && erase) completion_time_next = req.now_ms + duration;
  end

  // Remaining time is taken against the updated completion time.
  assign time_left = (completion_time_next > req.now_ms) ?
                     (completion_time_next - req.now_ms) : 32'd0;

  always_comb begin
    wr_en              = '0;
    wr_en.command_byte = CMD_WRITE_ENABLE;
    wr_en.time_left_ms = time_left;

    main              = '0;
    main.time_left_ms = time_left;
    main.last         = 1'b1;

    pair.two    = 1'b0;
    pair.first  = main;
    pair.second = main;

    if (!ok) begin
      pair.first.rejected = 1'b1;
    end else if (erase) begin
      pair.two                 = 1'b1;
      pair.first               = wr_en;
      pair.second.command_byte = erase_cmd;
      pair.second.spi_address  = erase_addr;
      if (req.opcode == OP_PROGRAM) pair.second.data_length = PAGE_BYTES;
    end else if (req.opcode == OP_READ) begin
      pair.first.command_byte = CMD_READ;
      pair.first.spi_address  = req.byte_address;
      pair.first.data_is_read = 1'b1;
      if (split) begin
        pair.two                 = 1'b1;
        pair.first.data_length   = first_len[26:0];
        pair.first.last          = 1'b0;
        pair.second.command_byte = CMD_READ;
        pair.second.spi_address  = DIE_BYTES[25:0];
        pair.second.data_length  = req.byte_count - first_len[26:0];
        pair.second.data_is_read = 1'b1;
      end else begin
        pair.first.data_length = req.byte_count;
      end
    end
  end

endmodule

[sv/sfcs_emit.sv]
`timescale 1ns / 1ps
// Result buffer that sends the one or two words of a request in order.
module sfcs_emit
  import sfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pair_valid,
  input  pair_t                 pair,
  output logic                  take,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  logic    buf_valid;
  logic    idx;
  pair_t   held;
  result_t word;
  logic    done_now;

  assign word     = idx ? held.second : held.first;
  assign done_now = buf_valid && m_tready && (idx || !held.two);
  assign take     = pair_valid && (!buf_valid || done_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (take) begin
      buf_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (done_now) begin
      buf_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (buf_valid && m_tready) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held <= pair;
  end

  assign m_tvalid = buf_valid;
  assign m_tdata  = {3'd0, word.time_left_ms, word.data_length,
                     word.spi_address, word.command_byte};
  assign m_tuser  = {word.rejected, word.data_is_read};
  assign m_tlast  = word.last;

endmodule

[sv/spi_flash_command_sequencer_core.sv]
`timescale 1ns / 1ps
// Top level of the SPI flash command sequencer.
//
// Each request word on the slave stream (read, page program, sector,
// subsector or die erase, time query) becomes one or two SPI transaction
// header words on the master stream. Program and erase requests send a
// write-enable word first; a read that crosses the die boundary is sent as
// two reads. Refused requests give a single word with the rejected flag set.
// The last header word of every request carries tlast.
// The configuration channel sets the estimated durations; write it only
// while no request is in flight. It is always ready.
// A request word passes through the input register and then the output
// buffer before its first header word is offered on the master side.
// Throughput: one header word per cycle while the receiver is ready, set by
// the single output buffer.
// A new request is taken while the previous request's words are still
// waiting, so back-to-back requests keep the output busy.
// When the receiver stalls, the current word holds steady and the input
// register fills, after which s_tready drops until words move again.
// Reset clears the completion time, the stage valid flags and restores
// the reset durations.
module spi_flash_command_sequencer_core
  import sfcs_pkg::*;
#(
  parameter logic [32:0] DIE_BYTES = 33'd33554432
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // opcode[2:0], byte_address[28:3], byte_count[55:29],
  // unit_number[73:56], now_ms[105:74], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command_byte[7:0], spi_address[33:8], data_length[60:34],
  // time_left_ms[92:61], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  // data_is_read[0], rejected[1]
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  pair_t pair;
  logic  pair_valid;
  logic  take;

  assign cfg_ready = 1'b1;

  sfcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfcs_decode #(
    .DIE_BYTES (DIE_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .take       (take),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  sfcs_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair       (pair),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[sv/sfcs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the SPI flash command sequencer, bound to the top level.
module sfcs_checker
  import sfcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser,
  input logic                  m_tlast
);

  // A stalled word stays offered.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A refusal is a single word with no command.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[7:0] == CMD_NONE))
    else $error("rejected word malformed");

  // Only a write enable or the first half of a split read is not last.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |->
      (m_tdata[7:0] == CMD_WRITE_ENABLE) || (m_tdata[7:0] == CMD_READ))
    else $error("unexpected non-final header word");

  // After a write enable is taken, the next word is a program or an erase.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata[7:0] == CMD_WRITE_ENABLE) |=>
      m_tvalid && ((m_tdata[7:0] == CMD_PROGRAM) ||
                   (m_tdata[7:0] == CMD_SECTOR_ERASE) ||
                   (m_tdata[7:0] == CMD_SUBSEC_ERASE) ||
                   (m_tdata[7:0] == CMD_DIE_ERASE)))
    else $error("write enable not followed by its command");

endmodule

bind spi_flash_command_sequencer_core sfcs_checker u_sfcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
